### rtl/mkrs_pkg.sv
// ----------------------------------------------------------------------------
// mkrs_pkg - shared types and constants of the multi-key record sorter
// Record layout, cell control group, sort key codes and the controller states.
// ----------------------------------------------------------------------------
package mkrs_pkg;

    localparam int ID_W     = 32;
    localparam int NAME_W   = 64;
    localparam int POINTS_W = 16;
    localparam int TAG_W    = 5;
    localparam int KEY_W    = 64;
    localparam int SEL_W    = 3;
    localparam int DATA_W   = 136;
    localparam int MAX_OUT  = 32;

    localparam logic [SEL_W-1:0] KEY_ID     = 3'd0;
    localparam logic [SEL_W-1:0] KEY_NAME   = 3'd1;
    localparam logic [SEL_W-1:0] KEY_TOTAL  = 3'd2;
    localparam logic [SEL_W-1:0] KEY_FIRST  = 3'd3;
    localparam logic [SEL_W-1:0] KEY_SECOND = 3'd4;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [POINTS_W-1:0] second;
        logic [POINTS_W-1:0] first;
        logic [NAME_W-1:0]   name;
        logic [ID_W-1:0]     id;
    } rec_t;

    typedef struct packed {
        rec_t             rec;
        logic [KEY_W-1:0] key;
    } cell_t;

    typedef struct packed {
        logic load;
        logic pop;
        logic flush;
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

### rtl/multi_key_record_sorter.sv
// ----------------------------------------------------------------------------
// multi_key_record_sorter - stable record sorter with a selectable key
// Insertion chain of record cells, loaded from a stream and drained in order.
// ----------------------------------------------------------------------------
// Usage. Records arrive on the s_ channel, one request per cycle while
// s_tready is high. Each record is inserted straight into its sorted place in
// a chain of RECORDS cells. The request with s_tlast high closes the set:
// from the next cycle the block drains the chain on the m_ channel, one
// record per accepted request, in ascending order of the key selected by the
// sort key register (id, name, total points, first or second sum). Records
// with equal keys leave in arrival order. m_tlast marks the final record of
// the run and m_tuser reports whether any record of the set was dropped
// because the chain was full; at most 32 records are emitted per run. The
// first result is offered in the cycle after the closing request. The
// single-ported chain either loads or drains, so no new set is taken until
// the run has been drained. While the receiver stalls, the current result is
// held in cell zero unchanged and no input is taken. Reset empties the chain,
// clears the dropped flag and sets the sort key to id. The sort key register
// must only be written while the block is idle between sets.
// ----------------------------------------------------------------------------
module multi_key_record_sorter #(
    parameter int RECORDS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [mkrs_pkg::SEL_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: id_number[31:0], name_code[95:32], first_points[111:96],
    // second_points[127:112], tag[132:128], zero fill[135:133]
    input  logic [mkrs_pkg::DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: out_id[31:0], out_name[95:32], out_first[111:96],
    // out_second[127:112], out_tag[132:128], zero fill[135:133]
    output logic [mkrs_pkg::DATA_W-1:0] m_tdata,
    // m_tuser: overflow[0]
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int CNT_W = $clog2(mkrs_pkg::MAX_OUT);

    mkrs_pkg::state_t      state_reg, state_next;
    logic [mkrs_pkg::SEL_W-1:0] sort_key_reg;
    logic                  dropped_reg, dropped_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    mkrs_pkg::rec_t        in_rec;
    mkrs_pkg::cell_t       new_cell;
    mkrs_pkg::cell_ctrl_t  ctrl;
    logic [mkrs_pkg::KEY_W-1:0] in_key;

    logic [RECORDS-1:0]    vld;
    logic [RECORDS-1:0]    ins;
    mkrs_pkg::cell_t       cell_q [RECORDS];

    logic                  in_acc, out_acc, full, run_end;

    // The sort key register; the user must write it between sets only, the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_key_reg <= mkrs_pkg::KEY_ID;
        end else if (cfg_wen) begin
            sort_key_reg <= cfg_wdata;
        end
    end

    assign in_rec = mkrs_pkg::rec_t'(s_tdata[132:0]);

    mkrs_key u_key (
        .rec      (in_rec),
        .sort_key (sort_key_reg),
        .key      (in_key)
    );

    assign new_cell.rec = in_rec;
    assign new_cell.key = in_key;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign full    = vld[RECORDS-1];
    // The run ends on the last stored record or when the result cap is met.
    assign m_tlast = !vld[1] || (cnt_reg == CNT_W'(mkrs_pkg::MAX_OUT - 1));
    assign run_end = out_acc && m_tlast;

    // A full chain drops the record, the closing one included.
    assign ctrl.load  = in_acc && !full;
    assign ctrl.pop   = out_acc;
    assign ctrl.flush = run_end;

    // The insertion chain. Cell zero holds the smallest key.
    for (genvar i = 0; i < RECORDS; i++) begin : g_cell
        logic            p_ins, p_vld, n_vld;
        mkrs_pkg::cell_t p_cell, n_cell;

        if (i == 0) begin : g_first
            assign p_ins  = 1'b0;
            assign p_vld  = 1'b0;
            assign p_cell = new_cell;
        end else begin : g_mid
            assign p_ins  = ins[i-1];
            assign p_vld  = vld[i-1];
            assign p_cell = cell_q[i-1];
        end

        if (i == RECORDS - 1) begin : g_last
            assign n_vld  = 1'b0;
            assign n_cell = cell_q[i];
        end else begin : g_inner
            assign n_vld  = vld[i+1];
            assign n_cell = cell_q[i+1];
        end

        mkrs_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_cell   (new_cell),
            .prev_ins   (p_ins),
            .prev_valid (p_vld),
            .prev_cell  (p_cell),
            .next_valid (n_vld),
            .next_cell  (n_cell),
            .ins        (ins[i]),
            .valid      (vld[i]),
            .slot       (cell_q[i])
        );
    end

    // Next state: load until the closing request, then drain the run.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mkrs_pkg::ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = mkrs_pkg::ST_DRAIN;
                end
            end
            mkrs_pkg::ST_DRAIN: begin
                if (run_end) begin
                    state_next = mkrs_pkg::ST_LOAD;
                end
            end
            default: state_next = mkrs_pkg::ST_LOAD;
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            mkrs_pkg::ST_LOAD:  s_tready = 1'b1;
            mkrs_pkg::ST_DRAIN: m_tvalid = 1'b1;
            default: begin
                s_tready = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    // The dropped flag is sticky for the set; the emit count limits the run.
    always_comb begin
        dropped_next = dropped_reg;
        cnt_next     = cnt_reg;
        if (in_acc && full) begin
            dropped_next = 1'b1;
        end
        if (run_end) begin
            dropped_next = 1'b0;
            cnt_next     = '0;
        end else if (out_acc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mkrs_pkg::ST_LOAD;
            dropped_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
            cnt_reg     <= cnt_next;
        end
    end

    assign m_tdata = {3'b000, cell_q[0].rec};
    assign m_tuser = dropped_reg;

    // The two channels are never open at the same time.
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    // A result is only offered from an occupied head cell.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> vld[0])
        else $error("result offered from an empty chain");

    // Occupied cells always form an unbroken run from cell zero.
    a_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld & (vld + RECORDS'(1))) == '0)
        else $error("gap in the cell chain");

    // After the final result the chain is empty and ready for a new set.
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (vld == '0)))
        else $error("chain not emptied at end of run");

endmodule

### rtl/mkrs_key.sv
// ----------------------------------------------------------------------------
// mkrs_key - sort key extraction
// Maps an incoming record to an unsigned 64-bit key for the selected field.
// ----------------------------------------------------------------------------
module mkrs_key (
    input  mkrs_pkg::rec_t                   rec,
    input  logic [mkrs_pkg::SEL_W-1:0]       sort_key,
    output logic [mkrs_pkg::KEY_W-1:0]       key
);

    logic [mkrs_pkg::NAME_W-1:0] name_masked;

    // Bytes from the first zero byte onwards take no part in the compare.
    always_comb begin
        logic stop;
        stop        = 1'b0;
        name_masked = '0;
        for (int b = 7; b >= 0; b--) begin
            if (rec.name[8*b +: 8] == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                name_masked[8*b +: 8] = rec.name[8*b +: 8];
            end
        end
    end

    always_comb begin
        unique case (sort_key)
            mkrs_pkg::KEY_NAME:   key = name_masked;
            mkrs_pkg::KEY_TOTAL:  key = {47'd0, ({1'b0, rec.first} + {1'b0, rec.second})};
            mkrs_pkg::KEY_FIRST:  key = {48'd0, rec.first};
            mkrs_pkg::KEY_SECOND: key = {48'd0, rec.second};
            default:              key = {32'd0, ~rec.id[31], rec.id[30:0]};
        endcase
    end

endmodule

### rtl/mkrs_cell.sv
// ----------------------------------------------------------------------------
// mkrs_cell - one slot of the insertion chain
// Holds one record with its key; shifts up on insertion and down on output.
// ----------------------------------------------------------------------------
module mkrs_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mkrs_pkg::cell_ctrl_t ctrl,
    input  mkrs_pkg::cell_t      new_cell,
    input  logic                 prev_ins,
    input  logic                 prev_valid,
    input  mkrs_pkg::cell_t      prev_cell,
    input  logic                 next_valid,
    input  mkrs_pkg::cell_t      next_cell,
    output logic                 ins,
    output logic                 valid,
    output mkrs_pkg::cell_t      slot
);

    logic            valid_reg, valid_next;
    mkrs_pkg::cell_t cell_reg, cell_next;

    // Strict less keeps equal keys in arrival order.
    assign ins = !valid_reg || (new_cell.key < cell_reg.key);

    always_comb begin
        valid_next = valid_reg;
        cell_next  = cell_reg;
        priority if (ctrl.flush) begin
            valid_next = 1'b0;
        end else if (ctrl.pop) begin
            valid_next = next_valid;
            cell_next  = next_cell;
        end else if (ctrl.load && ins) begin
            if (prev_ins) begin
                valid_next = prev_valid;
                cell_next  = prev_cell;
            end else begin
                valid_next = 1'b1;
                cell_next  = new_cell;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
    end

    assign valid = valid_reg;
    assign slot  = cell_reg;

endmodule

### verif/multi_key_record_sorter_checker.sv
// ----------------------------------------------------------------------------
// multi_key_record_sorter_checker - sorted order checker
// Watches the key register and both streams, keeps its own copy of the loaded
// records, sorts each closed set stably by the selected key and compares every
// drained record with the oldest record still due.
// ----------------------------------------------------------------------------
module multi_key_record_sorter_checker #(
    parameter int RECORDS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wen,
    input  logic [mkrs_pkg::SEL_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [mkrs_pkg::DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [mkrs_pkg::DATA_W-1:0] m_tdata,
    input  logic                        m_tuser,
    input  logic                        m_tlast,
    output int                          mismatches,
    output int                          records_due,
    output int                          records_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        mkrs_pkg::rec_t rec;
        logic           overflow;
        logic           closing;
    } sorted_rec_t;

    mkrs_pkg::rec_t             loaded [RECORDS];
    int                         fill = 0;
    bit                         dropped = 0;
    logic [mkrs_pkg::SEL_W-1:0] key_sel = mkrs_pkg::KEY_ID;
    sorted_rec_t                due_q[$];
    int                         bad = 0;
    int                         checked = 0;

    // Sort key of one record. Names stop at their first zero byte; ids are
    // offset so that an unsigned compare orders them as signed numbers.
    function automatic logic [mkrs_pkg::KEY_W-1:0] rank_of(mkrs_pkg::rec_t r,
                                                        logic [mkrs_pkg::SEL_W-1:0] sel);
        logic [mkrs_pkg::KEY_W-1:0] v;
        bit                         ended;
        v = '0;
        ended = 1'b0;
        case (sel)
            mkrs_pkg::KEY_NAME: begin
                for (int b = 7; b >= 0; b--) begin
                    if (r.name[8*b +: 8] == 8'h00)
                        ended = 1'b1;
                    if (!ended)
                        v[8*b +: 8] = r.name[8*b +: 8];
                end
            end
            mkrs_pkg::KEY_TOTAL:
                v = mkrs_pkg::KEY_W'(r.first) + mkrs_pkg::KEY_W'(r.second);
            mkrs_pkg::KEY_FIRST:  v = mkrs_pkg::KEY_W'(r.first);
            mkrs_pkg::KEY_SECOND: v = mkrs_pkg::KEY_W'(r.second);
            default:              v = mkrs_pkg::KEY_W'(r.id ^ 32'h8000_0000);
        endcase
        return v;
    endfunction

    // Stable insertion sort of the loaded set; only a strictly smaller key
    // moves a record ahead of an earlier one.
    task automatic sort_loaded_set();
        int                         order [RECORDS];
        int                         j;
        int                         emit;
        logic [mkrs_pkg::KEY_W-1:0] k;
        sorted_rec_t                e;
        for (int i = 0; i < fill; i++) begin
            k = rank_of(loaded[i], key_sel);
            j = i;
            while (j > 0 && k < rank_of(loaded[order[j-1]], key_sel)) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        emit = (fill < mkrs_pkg::MAX_OUT) ? fill : mkrs_pkg::MAX_OUT;
        for (int i = 0; i < emit; i++) begin
            e.rec = loaded[order[i]];
            e.overflow = dropped;
            e.closing = (i == emit - 1);
            due_q.push_back(e);
        end
        fill = 0;
        dropped = 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        bad++;
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : watch
        mkrs_pkg::rec_t got;
        sorted_rec_t    want;
        if (!aresetn) begin
            fill = 0;
            dropped = 1'b0;
            key_sel = mkrs_pkg::KEY_ID;
            due_q.delete();
        end else begin
            if (cfg_wen)
                key_sel = cfg_wdata;
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(mkrs_pkg::rec_t)-1:0];
                checked++;
                if (due_q.size() == 0) begin
                    report_mismatch("record with none due, id", 64'(got.id), '0);
                end else begin
                    want = due_q.pop_front();
                    if (got.id !== want.rec.id)
                        report_mismatch("id", 64'(got.id), 64'(want.rec.id));
                    if (got.name !== want.rec.name)
                        report_mismatch("name", got.name, want.rec.name);
                    if (got.first !== want.rec.first)
                        report_mismatch("first sum", 64'(got.first), 64'(want.rec.first));
                    if (got.second !== want.rec.second)
                        report_mismatch("second sum", 64'(got.second),
                                        64'(want.rec.second));
                    if (got.tag !== want.rec.tag)
                        report_mismatch("tag", 64'(got.tag), 64'(want.rec.tag));
                    if (m_tuser !== want.overflow)
                        report_mismatch("overflow", 64'(m_tuser), 64'(want.overflow));
                    if (m_tlast !== want.closing)
                        report_mismatch("last", 64'(m_tlast), 64'(want.closing));
                end
            end
            if (s_tvalid && s_tready) begin
                if (fill < RECORDS) begin
                    loaded[fill] = s_tdata[$bits(mkrs_pkg::rec_t)-1:0];
                    fill++;
                end else begin
                    dropped = 1'b1;
                end
                if (s_tlast)
                    sort_loaded_set();
            end
        end
        mismatches <= bad;
        records_due <= due_q.size();
        records_checked <= checked;
    end

endmodule

### verif/multi_key_record_sorter_tb.sv
// ----------------------------------------------------------------------------
// multi_key_record_sorter_tb - record sorter testbench
// Feeds sets of records under every sort key, from hand-picked extremes to
// random sets with many equal keys and overfull sets, and lets the checker
// compare each drained record with a stable sort of what was loaded.
// ----------------------------------------------------------------------------
module multi_key_record_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAIN_DEPTH = 32;
    // The sorter treats key codes above the second sum as an id sort.
    localparam logic [mkrs_pkg::SEL_W-1:0] KEY_SPARE_TOP = 3'd7;
    // Length of the deliberate receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_PERCENT = 29;
    localparam int RANDOM_ITEMS = 230;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wen;
    logic [mkrs_pkg::SEL_W-1:0]  cfg_wdata;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [mkrs_pkg::DATA_W-1:0] s_tdata;
    logic                        s_tlast;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [mkrs_pkg::DATA_W-1:0] m_tdata;
    logic                        m_tuser;
    logic                        m_tlast;

    int mismatches;
    int records_due;
    int records_checked;

    int items_sent = 0;
    int sets_sent = 0;
    int overfull_sets = 0;
    // calm switches off idling on both sides; hold_arm asks the receiver for
    // one long hold-off as soon as the next drain begins.
    bit calm = 1'b0;
    bit hold_arm = 1'b0;

    multi_key_record_sorter #(
        .RECORDS  (CHAIN_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    multi_key_record_sorter_checker #(
        .RECORDS  (CHAIN_DEPTH)
    ) order_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .records_due     (records_due),
        .records_checked (records_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard limit on the run; a correct run finishes in a small fraction of it.
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver. It normally stalls about 29 percent of the time. When armed it
    // holds off for a long stretch at the start of a drain, so that the chain
    // stays occupied while the sender keeps offering the next set and the block
    // has to stall its input.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_arm && m_tvalid) begin
                hold_arm = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    function automatic mkrs_pkg::rec_t make_record(logic [mkrs_pkg::ID_W-1:0] id,
                                                   logic [mkrs_pkg::NAME_W-1:0] name,
                                                   logic [mkrs_pkg::POINTS_W-1:0] first,
                                                   logic [mkrs_pkg::POINTS_W-1:0] second,
                                                   logic [mkrs_pkg::TAG_W-1:0] tag);
        mkrs_pkg::rec_t r;
        r.id = id;
        r.name = name;
        r.first = first;
        r.second = second;
        r.tag = tag;
        return r;
    endfunction

    // Half of the random records draw from narrow ranges, so that equal keys
    // are common and the stability of the sort is exercised; names then mix
    // zero bytes into the middle. The other half use the full field widths.
    function automatic mkrs_pkg::rec_t random_record();
        mkrs_pkg::rec_t r;
        r.tag = mkrs_pkg::TAG_W'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            r.id = mkrs_pkg::ID_W'($urandom_range(0, 6)) - 32'd3;
            for (int b = 0; b < 8; b++) begin
                case ($urandom_range(0, 3))
                    0:       r.name[8*b +: 8] = 8'h00;
                    1:       r.name[8*b +: 8] = 8'h41;
                    2:       r.name[8*b +: 8] = 8'h42;
                    default: r.name[8*b +: 8] = 8'hFF;
                endcase
            end
            r.first = mkrs_pkg::POINTS_W'($urandom_range(0, 3));
            r.second = mkrs_pkg::POINTS_W'($urandom_range(0, 3));
            if ($urandom_range(0, 7) == 0)
                r.first = 16'hFFFF;
            if ($urandom_range(0, 7) == 0)
                r.second = 16'hFFFF;
        end else begin
            r.id = mkrs_pkg::ID_W'($urandom);
            r.name = {32'($urandom), 32'($urandom)};
            r.first = mkrs_pkg::POINTS_W'($urandom);
            r.second = mkrs_pkg::POINTS_W'($urandom);
        end
        return r;
    endfunction

    // Offers one record and returns at the edge where the request is taken.
    // s_tvalid stays high afterwards, so a following record is offered
    // back to back unless an idle cycle is drawn.
    task automatic send_record(mkrs_pkg::rec_t r, bit closing);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= mkrs_pkg::DATA_W'(r);
        s_tlast <= closing;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (closing)
            sets_sent++;
    endtask

    // The key may only change while the sorter is idle: the sender pauses
    // until every sorted record has come back, lets the chain settle into
    // loading again, and then writes the register.
    task automatic select_key(logic [mkrs_pkg::SEL_W-1:0] key);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (records_due != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= key;
        @(posedge aclk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        int set_no;
        int set_size;
        aresetn = 1'b0;
        cfg_wen = 1'b0;
        cfg_wdata = mkrs_pkg::KEY_ID;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Signed id extremes, with a tie on zero that must keep arrival order,
        // followed by a set of a single record.
        select_key(mkrs_pkg::KEY_ID);
        send_record(make_record(32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'h0000,
                                5'd31), 1'b0);
        send_record(make_record(32'h8000_0000, 64'h0, 16'h0000, 16'hFFFF, 5'd0), 1'b0);
        send_record(make_record(32'h0000_0000, 64'h4142_4300_0000_0000, 16'd1234, 16'd1,
                                5'd1), 1'b0);
        send_record(make_record(32'hFFFF_FFFF, 64'h0100_0000_0000_0000, 16'd1, 16'd1,
                                5'd2), 1'b0);
        send_record(make_record(32'h0000_0000, 64'h5A00_0000_0000_0000, 16'd2, 16'd2,
                                5'd3), 1'b1);
        send_record(make_record(32'h5A5A_5A5A, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 16'hAAAA,
                                5'd21), 1'b1);

        // Names: bytes after the first zero byte are ignored, so the first two
        // names tie; the empty name comes first and the all-ones name last.
        select_key(mkrs_pkg::KEY_NAME);
        send_record(make_record(32'd1, 64'h4142_0058_0000_0000, 16'd0, 16'd0, 5'd4), 1'b0);
        send_record(make_record(32'd2, 64'h4142_0059_0000_0000, 16'd0, 16'd0, 5'd5), 1'b0);
        send_record(make_record(32'd3, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd0, 5'd6), 1'b0);
        send_record(make_record(32'd4, 64'h0, 16'd0, 16'd0, 5'd7), 1'b0);
        send_record(make_record(32'd5, 64'h4100_0000_0000_0000, 16'd0, 16'd0, 5'd8), 1'b1);

        // Total points need the seventeenth bit; the last two records tie.
        select_key(mkrs_pkg::KEY_TOTAL);
        send_record(make_record(32'd1, 64'h1, 16'hFFFF, 16'hFFFF, 5'd9), 1'b0);
        send_record(make_record(32'd2, 64'h2, 16'h0001, 16'h0000, 5'd10), 1'b0);
        send_record(make_record(32'd3, 64'h3, 16'h0000, 16'h0001, 5'd11), 1'b1);

        select_key(mkrs_pkg::KEY_FIRST);
        send_record(make_record(32'd1, 64'h1, 16'hFFFF, 16'h0000, 5'd12), 1'b0);
        send_record(make_record(32'd2, 64'h2, 16'h0000, 16'hFFFF, 5'd13), 1'b1);

        select_key(mkrs_pkg::KEY_SECOND);
        send_record(make_record(32'd1, 64'h1, 16'hFFFF, 16'h0000, 5'd14), 1'b0);
        send_record(make_record(32'd2, 64'h2, 16'h0000, 16'hFFFF, 5'd15), 1'b1);

        // A spare key code falls back to the id order.
        select_key(KEY_SPARE_TOP);
        send_record(make_record(32'hFFFF_FFFB, 64'h1, 16'd7, 16'd7, 5'd16), 1'b0);
        send_record(make_record(32'd3, 64'h2, 16'd1, 16'd1, 5'd17), 1'b1);

        // Random sets. A few sizes are fixed: a set that exactly fills the
        // chain, one whose closing record is dropped, and one well past
        // capacity. Sets three and nine are drained under a long receiver
        // hold-off while the following set, sorted by the same key, is
        // already being offered. One stretch runs with no idling at all.
        set_no = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (set_no != 4 && set_no != 10)
                select_key(mkrs_pkg::SEL_W'($urandom_range(0, 7)));
            case (set_no)
                1:       set_size = CHAIN_DEPTH;
                5:       set_size = CHAIN_DEPTH + 1;
                7:       set_size = CHAIN_DEPTH + 8;
                default: set_size = $urandom_range(1, 8);
            endcase
            if (set_no == 3 || set_no == 9)
                hold_arm = 1'b1;
            calm = (items_sent >= 140 && items_sent < 190);
            for (int i = 0; i < set_size; i++)
                send_record(random_record(), i == set_size - 1);
            if (set_size > CHAIN_DEPTH)
                overfull_sets++;
            set_no++;
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (records_due != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Loaded %0d records in %0d sets across the key codes, %0d sets overfull.",
                 items_sent, sets_sent, overfull_sets);
        $display("Compared %0d sorted records field by field, %0d mismatches found.",
                 records_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### multi_key_record_sorter.f
rtl/mkrs_pkg.sv
rtl/mkrs_key.sv
rtl/mkrs_cell.sv
rtl/multi_key_record_sorter.sv
verif/multi_key_record_sorter_checker.sv
verif/multi_key_record_sorter_tb.sv
